### src/baro_temp_pressure_compensation_unit_assert.svh
// Assertion macros for the compensation unit
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_UNIT_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_UNIT_ASSERT_SVH

// Implication checked while out of reset
`define BTPC_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Implication checked at every edge, reset included
`define BTPC_ASSERT_ALWAYS(lbl, clk, pre, post, msg) \
   lbl: assert property (@(posedge clk) (pre) |-> (post)) else $error(msg);

`endif

### src/btpc_pkg.sv
package btpc_pkg;

   localparam int CsrIdxW = 2;
   localparam logic [CsrIdxW-1:0] REG_TEMP    = 2'd0;
   localparam logic [CsrIdxW-1:0] REG_PRESS_A = 2'd1;
   localparam logic [CsrIdxW-1:0] REG_PRESS_B = 2'd2;
   localparam logic [CsrIdxW-1:0] REG_PRESS_9 = 2'd3;

   // stage map: front 0..9, divider 10..41, back 42..44
   localparam int FrontDepth = 10;
   localparam int DivFirst   = 10;
   localparam int DivDepth   = 32;
   localparam int BackFirst  = DivFirst + DivDepth;
   localparam int BackDepth  = 3;

   typedef struct packed {
      logic [31:0] t1, t2, t3;
      logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
   } coef_type;

   typedef struct packed {
      logic [19:0] adc_t;
      logic [19:0] adc_p;
      logic [31:0] temp;
      logic [31:0] w0, w1, w2, w3;
      logic [31:0] div;
      logic [31:0] rem;
      logic        dbl;
      logic        inv;
   } item_type;

   function automatic logic [31:0] asr(input logic [31:0] x, input int n);
      asr = 32'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
      mul = 32'(a * b);
   endfunction

   function automatic item_type btpc_stage(input int k, input item_type i,
                                           input coef_type c);
      item_type    o;
      logic [32:0] r;
      logic [31:0] p;
      o = i;
      r = 33'd0;
      p = 32'd0;
      priority if (k == 0) begin
         o.w0 = mul(32'(i.adc_t >> 3) - (c.t1 << 1), c.t2);
         o.w1 = mul(32'(i.adc_t >> 4) - c.t1, 32'(i.adc_t >> 4) - c.t1);
      end else if (k == 1) begin
         o.w0 = asr(i.w0, 11);
         o.w1 = mul(asr(i.w1, 12), c.t3);
      end else if (k == 2) begin
         o.w0 = i.w0 + asr(i.w1, 14);
      end else if (k == 3) begin
         o.temp = asr((i.w0 << 2) + i.w0 + 32'd128, 8);
         o.w0   = asr(i.w0, 1) - 32'd64000;
      end else if (k == 4) begin
         o.w1 = mul(asr(i.w0, 2), asr(i.w0, 2));
         o.w2 = mul(i.w0, c.p5);
         o.w3 = mul(c.p2, i.w0);
      end else if (k == 5) begin
         o.w0 = mul(asr(i.w1, 11), c.p6);
         o.w1 = mul(c.p3, asr(i.w1, 13));
      end else if (k == 6) begin
         o.w0 = asr(i.w0 + (i.w2 << 1), 2) + (c.p4 << 16);
         o.w1 = asr(asr(i.w1, 3) + asr(i.w3, 1), 18);
      end else if (k == 7) begin
         o.w1 = mul(32'd32768 + i.w1, c.p1);
         o.w0 = (32'd1048576 - 32'(i.adc_p)) - asr(i.w0, 12);
      end else if (k == 8) begin
         o.div = asr(i.w1, 15);
         o.w0  = mul(i.w0, 32'd3125);
      end else if (k == 9) begin
         o.inv = (i.div == 32'd0);
         o.dbl = i.w0[31];
         o.w0  = i.w0[31] ? i.w0 : (i.w0 << 1);
         o.w1  = 32'd0;
         o.rem = 32'd0;
      end else if (k < BackFirst) begin
         r    = {i.rem, i.w0[31]};
         o.w0 = {i.w0[30:0], 1'b0};
         if (r >= {1'b0, i.div}) begin
            r    = r - {1'b0, i.div};
            o.w1 = {i.w1[30:0], 1'b1};
         end else begin
            o.w1 = {i.w1[30:0], 1'b0};
         end
         o.rem = r[31:0];
      end else if (k == BackFirst) begin
         p    = i.dbl ? (i.w1 << 1) : i.w1;
         o.w0 = p;
         o.w1 = mul(p >> 3, p >> 3);
         o.w2 = mul(p >> 2, c.p8);
      end else if (k == BackFirst + 1) begin
         o.w1 = mul(i.w1 >> 13, c.p9);
      end else begin
         o.w0 = i.inv ? 32'd0
                      : i.w0 + asr(asr(i.w1, 12) + asr(i.w2, 13) + c.p7, 4);
      end
      return o;
   endfunction

endpackage

### src/btpc_pipe.sv
module btpc_pipe #(
   parameter int BASE  = 0,
   parameter int DEPTH = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  btpc_pkg::coef_type coef,
   input  logic               in_valid,
   output logic               in_ready,
   input  btpc_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output btpc_pkg::item_type out_item
);
   import btpc_pkg::*;

   logic     [DEPTH-1:0] valid_ff;
   item_type             data_ff [DEPTH];
   logic     [DEPTH:0]   en;

   assign en[DEPTH] = out_ready;

   for (genvar g = 0; g < DEPTH; g++) begin : g_stage
      item_type src;
      logic     src_v;
      item_type data_in;

      assign en[g] = !valid_ff[g] || en[g+1];

      if (g == 0) begin : g_first
         assign src   = in_item;
         assign src_v = in_valid;
      end else begin : g_next
         assign src   = data_ff[g-1];
         assign src_v = valid_ff[g-1];
      end

      assign data_in = btpc_stage(BASE + g, src, coef);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en[g]) begin
            valid_ff[g] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en[g] && src_v) begin
            data_ff[g] <= data_in;
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = valid_ff[DEPTH-1];
   assign out_item  = data_ff[DEPTH-1];

endmodule

### src/baro_temp_pressure_compensation_unit.sv
// Barometric temperature/pressure compensation, 32-bit integer scheme.
// req_ channel: one word per raw reading pair; tdata = raw_temperature[19:0],
//   raw_pressure[39:20]. Taken when req_tvalid and req_tready are high.
// rsp_ channel: one word per request, in order; tdata = temperature_centi
//   [31:0], pressure_pa [63:32]; tuser = pressure_invalid (divisor zero,
//   pressure then reads 0).
// csr_ channel: always ready; csr_index selects the calibration register
//   (0 temp coeffs, 1 pressure P1..P4, 2 pressure P5..P8, 3 P9). Write only
//   while no request is in flight.
// Throughput: one word per cycle while rsp_tready is high. The pipeline
//   holds 10 arithmetic stages (at most one 32x32 multiply deep per
//   stage), a 32-stage restoring divider producing one quotient bit per
//   stage, and 3 correction stages.
// Reset clears all calibration registers and empties the pipeline.
// When rsp_tready is low the last stage holds its word; earlier stages keep
//   advancing into empty slots, so req_tready drops only once all are full.
module baro_temp_pressure_compensation_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // raw_temperature, raw_pressure
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // temperature_centi, pressure_pa
   output logic        rsp_tuser,   // pressure_invalid
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [btpc_pkg::CsrIdxW-1:0] csr_index,
   input  logic [63:0] csr_data
);
   import btpc_pkg::*;

   logic [47:0] temp_coeffs_ff;
   logic [63:0] press_a_ff;
   logic [63:0] press_b_ff;
   logic [15:0] press_9_ff;
   coef_type    coef;
   item_type    in_item, f_item, d_item, b_item;
   logic        f_v, f_r, d_v, d_r;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         press_a_ff     <= '0;
         press_b_ff     <= '0;
         press_9_ff     <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_TEMP:    temp_coeffs_ff <= csr_data[47:0];
            REG_PRESS_A: press_a_ff     <= csr_data;
            REG_PRESS_B: press_b_ff     <= csr_data;
            REG_PRESS_9: press_9_ff     <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   assign coef.t1 = {16'd0, temp_coeffs_ff[15:0]};
   assign coef.t2 = 32'($signed(temp_coeffs_ff[31:16]));
   assign coef.t3 = 32'($signed(temp_coeffs_ff[47:32]));
   assign coef.p1 = {16'd0, press_a_ff[15:0]};
   assign coef.p2 = 32'($signed(press_a_ff[31:16]));
   assign coef.p3 = 32'($signed(press_a_ff[47:32]));
   assign coef.p4 = 32'($signed(press_a_ff[63:48]));
   assign coef.p5 = 32'($signed(press_b_ff[15:0]));
   assign coef.p6 = 32'($signed(press_b_ff[31:16]));
   assign coef.p7 = 32'($signed(press_b_ff[47:32]));
   assign coef.p8 = 32'($signed(press_b_ff[63:48]));
   assign coef.p9 = 32'($signed(press_9_ff));

   always_comb begin
      in_item       = '0;
      in_item.adc_t = req_tdata[19:0];
      in_item.adc_p = req_tdata[39:20];
   end

   btpc_pipe #(.BASE(0), .DEPTH(FrontDepth)) u_front (
      .clock(clock), .reset(reset), .coef(coef),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(in_item),
      .out_valid(f_v), .out_ready(f_r), .out_item(f_item)
   );

   btpc_pipe #(.BASE(DivFirst), .DEPTH(DivDepth)) u_div (
      .clock(clock), .reset(reset), .coef(coef),
      .in_valid(f_v), .in_ready(f_r), .in_item(f_item),
      .out_valid(d_v), .out_ready(d_r), .out_item(d_item)
   );

   btpc_pipe #(.BASE(BackFirst), .DEPTH(BackDepth)) u_back (
      .clock(clock), .reset(reset), .coef(coef),
      .in_valid(d_v), .in_ready(d_r), .in_item(d_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_item(b_item)
   );

   assign rsp_tdata = {b_item.w0, b_item.temp};
   assign rsp_tuser = b_item.inv;

`include "baro_temp_pressure_compensation_unit_assert.svh"

   `BTPC_ASSERT_IMP(a_inv_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[63:32] == 32'd0, "invalid word with nonzero pressure")
   `BTPC_ASSERT_IMP(a_empty_ready, clock, reset, !rsp_tvalid, req_tready, "empty output stage but request stalled")
   `BTPC_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset), !rsp_tvalid, "response valid right after reset")

endmodule
